@@ src/bdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpt_pkg
// shared types and constants for the push button debouncer with toggle
// ----------------------------------------------------------------------------
package bdpt_pkg;

    localparam int TimeW    = 16;
    localparam int ModeW    = 2;
    localparam int CfgDataW = 16;
    localparam int CfgIdxW  = 1;
    localparam int InDataW  = 24;
    localparam int OutDataW = 8;

    localparam logic [CfgIdxW-1:0] RegSettleDelay = 1'd0;
    localparam logic [CfgIdxW-1:0] RegButtonMode  = 1'd1;

    localparam logic [TimeW-1:0] SettleDelayReset = 16'd20;
    localparam logic [ModeW-1:0] ButtonModeReset  = 2'd0;

    typedef struct packed {
        logic [TimeW-1:0] settle_delay_ms;
        logic [ModeW-1:0] button_mode;
    } cfg_t;

    typedef struct packed {
        logic             last_level;
        logic [TimeW-1:0] window_start;
        logic             pressed_flag;
    } state_t;

    typedef struct packed {
        logic toggle_event;
        logic release_event;
        logic press_event;
        logic is_pressed;
    } result_t;

endpackage

@@ src/bdpt_step.sv @@
// ----------------------------------------------------------------------------
// bdpt_step
// next-state and event logic for one poll item
// ----------------------------------------------------------------------------
module bdpt_step
(
    input  bdpt_pkg::cfg_t                 cfg,
    input  bdpt_pkg::state_t               state,
    input  logic                           pin_level,
    input  logic [bdpt_pkg::TimeW-1:0]     now_ms,
    output bdpt_pkg::state_t               state_next,
    output bdpt_pkg::result_t              result
);

    logic                       inverse;
    logic                       toggle;
    logic                       equal;
    logic                       active_old;
    logic                       active_new;
    logic                       window_open;
    logic [bdpt_pkg::TimeW-1:0] passed;
    logic                       reached;
    logic                       expired;
    logic                       act;
    logic                       settle;
    logic                       flag_next;

    always_comb
    begin
        inverse     = cfg.button_mode[0];
        toggle      = cfg.button_mode[1];
        equal       = (state.last_level == pin_level);
        active_old  = state.last_level ^ inverse;
        active_new  = pin_level ^ inverse;
        window_open = (state.window_start != '0);
        passed      = now_ms - state.window_start;
        reached     = (passed >= cfg.settle_delay_ms);
        expired     = (passed > cfg.settle_delay_ms);

        if (window_open && reached)
        begin
            act = 1'b1;
        end
        else if (active_old && equal && state.pressed_flag)
        begin
            act = 1'b0;
        end
        else if (!active_old && !equal)
        begin
            act = 1'b1;
        end
        else if (!toggle && state.pressed_flag && (!pin_level || inverse))
        begin
            act = 1'b1;
        end
        else
        begin
            act = 1'b0;
        end

        // a window opened by this poll cannot settle on the same poll
        settle = window_open && expired;

        state_next.last_level   = pin_level;
        state_next.window_start = state.window_start;
        state_next.pressed_flag = state.pressed_flag;

        if (act)
        begin
            flag_next = toggle ? state.pressed_flag : 1'b0;
            if (settle)
            begin
                if (active_new)
                begin
                    flag_next = toggle ? ~state.pressed_flag : 1'b1;
                end
                state_next.window_start = '0;
            end
            else if (!window_open && active_new)
            begin
                state_next.window_start = now_ms;
            end
            state_next.pressed_flag = flag_next;
        end
        else
        begin
            flag_next = state.pressed_flag;
        end

        result.is_pressed    = flag_next;
        result.press_event   = !state.pressed_flag && flag_next;
        result.release_event = state.pressed_flag && !flag_next;
        result.toggle_event  = state.pressed_flag != flag_next;
    end

endmodule

@@ src/button_debounce_push_toggle.sv @@
// ----------------------------------------------------------------------------
// button_debounce_push_toggle
// push button debouncer with push and toggle modes
// ----------------------------------------------------------------------------
// Each poll item (raw pin level and a wrapping millisecond time) gives one
// result item with the debounced pressed flag and press, release and toggle
// pulses. One item is taken per clock cycle when not stalled; its result appears
// in the output register on the following cycle. A new item is taken in the same
// cycle the previous result is taken, so polls flow back to back; while a result
// is stalled in the output register the input is held off. The debounce state is
// updated in the cycle an item is taken, so the next item sees it at once.
module button_debounce_push_toggle
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bdpt_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [bdpt_pkg::CfgDataW-1:0]    cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bdpt_pkg::InDataW-1:0]     s_tdata,   // pin_level, now_ms, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdpt_pkg::OutDataW-1:0]    m_tdata    // is_pressed, press_event,
                                                        // release_event, toggle_event, pad
);

    bdpt_pkg::cfg_t    cfg_reg;
    bdpt_pkg::state_t  state_reg;
    bdpt_pkg::state_t  state_next;
    bdpt_pkg::result_t result;
    bdpt_pkg::result_t out_data_reg;
    logic              out_valid_reg;
    logic              accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bdpt_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pin_level  (s_tdata[0]),
        .now_ms     (s_tdata[bdpt_pkg::TimeW:1]),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_delay_ms <= bdpt_pkg::SettleDelayReset;
            cfg_reg.button_mode     <= bdpt_pkg::ButtonModeReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bdpt_pkg::RegSettleDelay: cfg_reg.settle_delay_ms <= cfg_data;
                bdpt_pkg::RegButtonMode:
                    cfg_reg.button_mode <= cfg_data[bdpt_pkg::ModeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bdpt_pkg::OutDataW - $bits(bdpt_pkg::result_t)){1'b0}}, out_data_reg};

endmodule

@@ src/bdpt_checker.sv @@
// ----------------------------------------------------------------------------
// bdpt_checker
// port-level checks for the button debouncer, bound to the top level
// ----------------------------------------------------------------------------
module bdpt_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bdpt_pkg::OutDataW-1:0]    m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // toggle pulse is exactly press or release
    a_toggle_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[1] || m_tdata[2])))
        else $error("toggle event mismatch");

    // events agree with the reported flag
    a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]) && (!m_tdata[2] || !m_tdata[0]))
        else $error("event disagrees with pressed flag");

    // every accepted item shows up as a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

endmodule

bind button_debounce_push_toggle bdpt_checker u_bdpt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
